FILE: rtl/core/jbt_pkg.sv
// jbt_pkg: shared types, character codes and lookup functions for the JSON byte tokenizer.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package jbt_pkg;

	typedef enum logic [3:0] {
		KIND_END      = 4'd0,
		KIND_LBRACE   = 4'd1,
		KIND_RBRACE   = 4'd2,
		KIND_LBRACKET = 4'd3,
		KIND_RBRACKET = 4'd4,
		KIND_COLON    = 4'd5,
		KIND_COMMA    = 4'd6,
		KIND_STRING   = 4'd7,
		KIND_NUMBER   = 4'd8,
		KIND_TRUE     = 4'd9,
		KIND_FALSE    = 4'd10,
		KIND_NULL     = 4'd11,
		KIND_INVALID  = 4'd12
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		kind_t       token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        end_of_run;
	} token_t;

	// work handed from front to back for one accepted byte
	typedef struct packed {
		logic       p1_valid;
		logic [7:0] p1_byte;
		logic [7:0] la;
		logic       p2_valid;
		logic       fin;
	} op_t;

	localparam int unsigned OPQ_DEPTH = 2;
	localparam int unsigned RESQ_DEPTH = 8;
	localparam int unsigned MAX_EMITS = 3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic space_char(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic kind_t symbol_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_LBRACK: k = KIND_LBRACKET;
			CH_RBRACK: k = KIND_RBRACKET;
			CH_COLON:  k = KIND_COLON;
			CH_COMMA:  k = KIND_COMMA;
			default:   k = KIND_END;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] lit_len(input kind_t k);
		logic [2:0] n;
		case (k)
			KIND_FALSE: n = 3'd5;
			default:    n = 3'd4;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] lit_char(input kind_t k, input logic [2:0] i);
		logic [7:0] c;
		c = CH_NUL;
		case (k)
			KIND_TRUE: begin
				case (i)
					3'd0:    c = "t";
					3'd1:    c = "r";
					3'd2:    c = "u";
					3'd3:    c = "e";
					default: c = CH_NUL;
				endcase
			end
			KIND_FALSE: begin
				case (i)
					3'd0:    c = "f";
					3'd1:    c = "a";
					3'd2:    c = "l";
					3'd3:    c = "s";
					3'd4:    c = "e";
					default: c = CH_NUL;
				endcase
			end
			KIND_NULL: begin
				case (i)
					3'd0:    c = "n";
					3'd1:    c = "u";
					3'd2:    c = "l";
					3'd3:    c = "l";
					default: c = CH_NUL;
				endcase
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jbt_front.sv
// jbt_front: accepts document bytes, holds one back for lookahead, and builds the work request
// for the token engine. Depends on jbt_pkg.
`default_nettype none

module jbt_front import jbt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	output logic          op_push,
	output op_t           op
);

	logic [7:0] held_q;
	logic       held_valid_q;
	logic       ended_q;
	logic       zero_byte;
	logic       finish;

	assign zero_byte = (item.data_byte == CH_NUL);
	assign finish = zero_byte || item.end_of_data;

	assign op_push = accept && !ended_q;

	always_comb begin
		op.p1_valid = held_valid_q;
		op.p1_byte = held_q;
		op.la = item.data_byte;
		op.p2_valid = item.end_of_data && !zero_byte;
		op.fin = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= CH_NUL;
			held_valid_q <= 1'b0;
			ended_q <= 1'b0;
		end else if (op_push) begin
			if (finish) begin
				held_q <= CH_NUL;
				held_valid_q <= 1'b0;
				ended_q <= 1'b1;
			end else begin
				held_q <= item.data_byte;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/jbt_op_queue.sv
// jbt_op_queue: short register queue of work requests between front and token engine.
// Depends on jbt_pkg.
`default_nettype none

module jbt_op_queue import jbt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  wdata,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output op_t       rdata
);

	localparam int unsigned IW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
	localparam int unsigned CW = $clog2(OPQ_DEPTH + 1);

	op_t           mem_q [OPQ_DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full = (count_q == CW'(OPQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	function automatic logic [IW-1:0] next_ptr(input logic [IW-1:0] p);
		return (p == IW'(OPQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/jbt_back.sv
// jbt_back: token engine; judges up to two bytes per request, closes the document, and writes
// up to three tokens per request into the result queue. Depends on jbt_pkg.
`default_nettype none

module jbt_back import jbt_pkg::*; #(
	parameter int unsigned POSITION_BITS = 16,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_empty,
	input  wire op_t  op,
	output logic      op_pop,
	input  wire logic res_space,
	output logic [1:0] res_count,
	output token_t    res_slot [MAX_EMITS]
);

	localparam int unsigned PB = POSITION_BITS;
	localparam int unsigned LB = LENGTH_BITS;

	typedef struct packed {
		kind_t         kind;
		logic [PB-1:0] start;
		logic [LB-1:0] len;
		logic          lit_ok;
	} tok_t;

	typedef struct packed {
		tok_t          tok;
		logic          emit;
		kind_t         ekind;
		logic [PB-1:0] estart;
		logic [LB-1:0] elen;
	} step_t;

	localparam tok_t TOK_CLEAR = '{kind: KIND_END, start: '0, len: '0, lit_ok: 1'b1};

	tok_t          tok_q;
	logic [PB-1:0] pos_q;
	step_t         s1;
	step_t         s2;
	tok_t          t1;
	tok_t          t2;
	logic [PB-1:0] pos_b;
	logic [3:0]    cand_v;
	token_t        cand [4];
	logic [2:0]    n;

	function automatic logic [PB-1:0] sat_pos(input logic [PB-1:0] p);
		return (p == '1) ? p : p + 1'b1;
	endfunction

	function automatic logic [LB-1:0] sat_len(input logic [LB-1:0] l);
		return (l == '1) ? l : l + 1'b1;
	endfunction

	function automatic step_t do_byte(input tok_t t, input logic [7:0] ch,
			input logic [PB-1:0] pos, input logic [7:0] la);
		step_t         r;
		kind_t         sk;
		logic [LB-1:0] nl;
		logic          ok;
		r.tok = t;
		r.emit = 1'b0;
		r.ekind = KIND_END;
		r.estart = pos;
		r.elen = LB'(1);
		sk = symbol_kind(ch);
		nl = sat_len(t.len);
		ok = 1'b0;
		case (t.kind)
			KIND_END: begin
				if (sk != KIND_END) begin
					r.emit = 1'b1;
					r.ekind = sk;
				end else if (ch == CH_QUOTE) begin
					r.tok.kind = KIND_STRING;
					r.tok.start = sat_pos(pos);
					r.tok.len = '0;
				end else if (digit_char(ch)) begin
					if ((la == CH_NUL) || (symbol_kind(la) != KIND_END)) begin
						r.emit = 1'b1;
						r.ekind = KIND_NUMBER;
					end else begin
						r.tok.kind = KIND_NUMBER;
						r.tok.start = pos;
						r.tok.len = LB'(1);
					end
				end else if ((ch == CH_MINUS) && digit_char(la)) begin
					r.tok.kind = KIND_NUMBER;
					r.tok.start = pos;
					r.tok.len = LB'(1);
				end else if ((ch == CH_T) || (ch == CH_F) || (ch == CH_N)) begin
					r.tok.kind = (ch == CH_T) ? KIND_TRUE : (ch == CH_F) ? KIND_FALSE : KIND_NULL;
					r.tok.start = pos;
					r.tok.len = LB'(1);
					r.tok.lit_ok = 1'b1;
				end else if (!space_char(ch)) begin
					r.emit = 1'b1;
					r.ekind = KIND_INVALID;
				end
			end
			KIND_STRING: begin
				if (ch == CH_QUOTE) begin
					r.emit = 1'b1;
					r.ekind = KIND_STRING;
					r.estart = t.start;
					r.elen = t.len;
					r.tok = TOK_CLEAR;
				end else begin
					r.tok.len = nl;
				end
			end
			KIND_NUMBER: begin
				r.estart = t.start;
				if (digit_char(ch)) begin
					if (!digit_char(la) && (la != CH_DOT)) begin
						r.emit = 1'b1;
						r.ekind = KIND_NUMBER;
						r.elen = nl;
						r.tok = TOK_CLEAR;
					end else begin
						r.tok.len = nl;
					end
				end else if (ch == CH_DOT) begin
					if (!digit_char(la)) begin
						r.emit = 1'b1;
						r.ekind = KIND_INVALID;
						r.elen = nl;
						r.tok = TOK_CLEAR;
					end else begin
						r.tok.len = nl;
					end
				end else begin
					r.emit = 1'b1;
					r.ekind = space_char(ch) ? KIND_NUMBER : KIND_INVALID;
					r.elen = t.len;
					r.tok = TOK_CLEAR;
				end
			end
			KIND_TRUE, KIND_FALSE, KIND_NULL: begin
				ok = t.lit_ok && (t.len < LB'(lit_len(t.kind)))
					&& (ch == lit_char(t.kind, t.len[2:0]));
				if (nl >= LB'(lit_len(t.kind))) begin
					r.emit = 1'b1;
					r.ekind = ok ? t.kind : KIND_INVALID;
					r.estart = t.start;
					r.elen = nl;
					r.tok = TOK_CLEAR;
				end else begin
					r.tok.len = nl;
					r.tok.lit_ok = ok;
				end
			end
			default: begin
				r.emit = 1'b1;
				r.ekind = KIND_INVALID;
				r.estart = t.start;
				r.elen = t.len;
				r.tok = TOK_CLEAR;
			end
		endcase
		return r;
	endfunction

	function automatic token_t mk_token(input kind_t k, input logic [PB-1:0] s,
			input logic [LB-1:0] l);
		token_t x;
		x.token_kind = k;
		x.token_start = 16'(s);
		x.token_length = 16'(l);
		x.end_of_run = 1'b0;
		return x;
	endfunction

	assign op_pop = !op_empty && res_space;

	always_comb begin
		s1 = do_byte(tok_q, op.p1_byte, pos_q, op.la);
		t1 = op.p1_valid ? s1.tok : tok_q;
		pos_b = op.p1_valid ? sat_pos(pos_q) : pos_q;
		s2 = do_byte(t1, op.la, pos_b, CH_NUL);
		t2 = op.p2_valid ? s2.tok : t1;

		cand_v[0] = op.p1_valid && s1.emit;
		cand_v[1] = op.p2_valid && s2.emit;
		cand_v[2] = op.fin && (t2.kind != KIND_END);
		cand_v[3] = op.fin;
		cand[0] = mk_token(s1.ekind, s1.estart, s1.elen);
		cand[1] = mk_token(s2.ekind, s2.estart, s2.elen);
		cand[2] = mk_token(KIND_INVALID, t2.start, t2.len);
		cand[3] = mk_token(KIND_END, '0, '0);

		n = '0;
		for (int i = 0; i < MAX_EMITS; i++) begin
			res_slot[i] = cand[3];
		end
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				if (n < 3'(MAX_EMITS)) begin
					res_slot[n[1:0]] = cand[i];
					n = n + 1'b1;
				end
			end
		end
		if (n != '0) begin
			res_slot[2'(n - 1'b1)].end_of_run = 1'b1;
		end
		res_count = op_pop ? n[1:0] : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= TOK_CLEAR;
			pos_q <= '0;
		end else if (op_pop) begin
			tok_q <= op.fin ? TOK_CLEAR : t2;
			pos_q <= pos_b;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/jbt_result_queue.sv
// jbt_result_queue: token queue that takes up to three tokens per cycle and gives one.
// Depends on jbt_pkg.
`default_nettype none

module jbt_result_queue import jbt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic [1:0] wr_count,
	input  wire token_t wr_slot [MAX_EMITS],
	output logic        space,
	input  wire logic   pop,
	output logic        empty,
	output token_t      rdata
);

	localparam int unsigned IW = $clog2(RESQ_DEPTH);
	localparam int unsigned CW = $clog2(RESQ_DEPTH + 1);

	token_t        mem_q [RESQ_DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign empty = (count_q == '0);
	assign space = (count_q <= CW'(RESQ_DEPTH - MAX_EMITS));
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_EMITS; i++) begin
			if (2'(i) < wr_count) begin
				mem_q[wr_ptr_q + IW'(i)] <= wr_slot[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + IW'(wr_count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(wr_count) - CW'(do_pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/json_byte_tokenizer_core.sv
// json_byte_tokenizer_core: top level of the JSON byte tokenizer.
// Instantiates jbt_front, jbt_op_queue, jbt_back and jbt_result_queue; depends on jbt_pkg.
//
// Usage:
//   Byte channel: drive item (data_byte, end_of_data) with push; a byte is taken at a clock
//   edge with push high and full low. One byte per cycle is sustained while full stays low.
//   Token channel: while empty is low, token holds the oldest token (kind, start, length,
//   end_of_run); it is taken at a clock edge with pop high, one per cycle while not empty.
//   A byte is judged when the byte after it arrives (one byte of lookahead); its tokens then
//   pass through the request queue and the result queue to the token ports. A final byte
//   or a zero byte closes the document in the same request, adding an invalid token for an
//   unfinished one and the end token.
//   Each request yields zero to three tokens; the token engine waits while the result queue
//   has fewer than three free entries, and the request queue between byte front and token
//   engine then fills, raising full. Stalls on pop thus reach push through both queues.
//   After the end token, bytes are still taken but dropped until reset.
//   Reset (arst_n low) clears the held byte, the token in progress, the byte offset and
//   both queues; no setup is needed after it.
`default_nettype none

module json_byte_tokenizer_core import jbt_pkg::*; #(
	parameter int unsigned POSITION_BITS = 16,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output token_t        token
);

	logic       op_push;
	op_t        op_in;
	op_t        op_out;
	logic       op_empty;
	logic       op_pop;
	logic       res_space;
	logic [1:0] res_count;
	token_t     res_slot [MAX_EMITS];

	jbt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (push && !full),
		.item    (item),
		.op_push (op_push),
		.op      (op_in)
	);

	jbt_op_queue u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_in),
		.full   (full),
		.pop    (op_pop),
		.empty  (op_empty),
		.rdata  (op_out)
	);

	jbt_back #(
		.POSITION_BITS (POSITION_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_empty  (op_empty),
		.op        (op_out),
		.op_pop    (op_pop),
		.res_space (res_space),
		.res_count (res_count),
		.res_slot  (res_slot)
	);

	jbt_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_count (res_count),
		.wr_slot  (res_slot),
		.space    (res_space),
		.pop      (pop),
		.empty    (empty),
		.rdata    (token)
	);

endmodule

`default_nettype wire
